@@ rtl/csq_pkg.sv @@
// Package for the counting semaphore with wait queue.
// Holds sizes, command codes, register indexes and the node pool request/response types.
// No dependencies.
package csq_pkg;

  localparam int unsigned POOL_NODES  = 64;
  localparam int unsigned PROCESSES   = 64;
  localparam int unsigned IDX_W       = $clog2(POOL_NODES);
  localparam int unsigned PROC_W      = $clog2(PROCESSES);
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned INIT_W      = 15;
  localparam int unsigned SCAN_W      = (POOL_NODES < 16) ? POOL_NODES : 16;
  localparam int unsigned SW_W        = $clog2(SCAN_W);
  localparam int unsigned SCAN_CHUNKS = (POOL_NODES + SCAN_W - 1) / SCAN_W;
  localparam int unsigned CHUNK_W     = (SCAN_CHUNKS > 1) ? $clog2(SCAN_CHUNKS) : 1;
  localparam int unsigned APB_AW      = 3;
  localparam int unsigned APB_DW      = 32;

  localparam logic CMD_ACQUIRE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [APB_AW-3:0] REG_INIT_COUNT = '0;

  localparam logic signed [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};
  localparam logic signed [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};

  typedef struct packed {
    logic             scan_start;
    logic             set_en;
    logic [IDX_W-1:0] set_idx;
    logic             clr_en;
    logic [IDX_W-1:0] clr_idx;
    logic             clr_all;
  } pool_req_t;

  typedef struct packed {
    logic             done;
    logic             found;
    logic [IDX_W-1:0] idx;
  } pool_rsp_t;

endpackage

@@ rtl/counting_semaphore_wait_queue.sv @@
// Counting semaphore with a FIFO wait queue linked through a private node pool.
// An acquire that blocks first runs the free-node scan, 16 nodes per cycle; a release
// that wakes passes through the wake state.
// The next transfer is taken once the result
// enters the output register.
// Reset: count 0, queue empty, all nodes free; writing init_count does the same with its value.
// Depends on csq_pkg and csq_node_pool.
module counting_semaphore_wait_queue import csq_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_AW-1:0]       paddr,
  input  logic [APB_DW-1:0]       pwdata,
  output logic [APB_DW-1:0]       prdata,
  output logic                    pready,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    cmd_i,
  input  logic [PROC_W-1:0]       proc_id_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    blocked_o,
  output logic                    woken_valid_o,
  output logic [PROC_W-1:0]       woken_proc_o,
  output logic                    pool_full_o,
  output logic signed [CNT_W-1:0] count_now_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAKE,
    ST_DONE
  } state_e;

  state_e                  state_q;
  logic [PROC_W-1:0]       pid_q;
  logic signed [CNT_W-1:0] count_q, dec_q, cnt_dec, cnt_inc;
  logic [INIT_W-1:0]       init_q;
  logic [IDX_W-1:0]        head_q, tail_q;
  logic                    empty_q;
  logic                    res_blocked_q, res_woken_valid_q, res_pool_full_q;
  logic [PROC_W-1:0]       res_woken_proc_q;
  logic                    out_valid_q, blocked_q, woken_valid_q, pool_full_q;
  logic [PROC_W-1:0]       woken_proc_q;
  logic signed [CNT_W-1:0] count_now_q;
  logic [PROC_W-1:0]       proc_mem [POOL_NODES];
  logic [IDX_W-1:0]        next_mem [POOL_NODES];
  logic [PROC_W-1:0]       rd_proc_q;
  logic [IDX_W-1:0]        rd_next_q;
  logic                    cfg_wr, in_xfer;
  pool_req_t               pool_req;
  pool_rsp_t               pool_rsp;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_INIT_COUNT);
  assign prdata  = (paddr[APB_AW-1:2] == REG_INIT_COUNT) ? APB_DW'(init_q) : '0;
  assign in_ready_o = (state_q == ST_IDLE) && !cfg_wr;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign cnt_dec = (count_q == CNT_MIN) ? count_q : count_q - CNT_W'(1);
  assign cnt_inc = (count_q == CNT_MAX) ? count_q : count_q + CNT_W'(1);

  always_comb begin
    pool_req.scan_start = in_xfer && (cmd_i == CMD_ACQUIRE) && cnt_dec[CNT_W-1];
    pool_req.set_en     = (state_q == ST_SCAN) && pool_rsp.found;
    pool_req.set_idx    = pool_rsp.idx;
    pool_req.clr_en     = (state_q == ST_WAKE);
    pool_req.clr_idx    = head_q;
    pool_req.clr_all    = cfg_wr;
  end

  csq_node_pool u_pool (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (pool_req),
    .rsp_o  (pool_rsp)
  );

  always_ff @(posedge clk_i) begin
    if (pool_req.set_en) begin
      proc_mem[pool_rsp.idx] <= pid_q;
      if (!empty_q) next_mem[tail_q] <= pool_rsp.idx;
    end
    rd_proc_q <= proc_mem[head_q];
    rd_next_q <= next_mem[head_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= ST_IDLE;
      pid_q             <= '0;
      count_q           <= '0;
      dec_q             <= '0;
      init_q            <= '0;
      head_q            <= '0;
      tail_q            <= '0;
      empty_q           <= 1'b1;
      res_blocked_q     <= 1'b0;
      res_woken_valid_q <= 1'b0;
      res_woken_proc_q  <= '0;
      res_pool_full_q   <= 1'b0;
      out_valid_q       <= 1'b0;
      blocked_q         <= 1'b0;
      woken_valid_q     <= 1'b0;
      woken_proc_q      <= '0;
      pool_full_q       <= 1'b0;
      count_now_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i && ((state_q != ST_DONE) || cfg_wr)) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_wr) begin
        init_q  <= pwdata[INIT_W-1:0];
        count_q <= {{(CNT_W-INIT_W){1'b0}}, pwdata[INIT_W-1:0]};
        head_q  <= '0;
        tail_q  <= '0;
        empty_q <= 1'b1;
      end else begin
        unique case (state_q)
          ST_IDLE: begin
            if (in_valid_i) begin
              pid_q             <= proc_id_i;
              dec_q             <= cnt_dec;
              res_blocked_q     <= 1'b0;
              res_woken_valid_q <= 1'b0;
              res_woken_proc_q  <= '0;
              res_pool_full_q   <= 1'b0;
              if (cmd_i == CMD_ACQUIRE) begin
                if (cnt_dec[CNT_W-1]) begin
                  state_q <= ST_SCAN;
                end else begin
                  count_q <= cnt_dec;
                  state_q <= ST_DONE;
                end
              end else begin
                count_q <= cnt_inc;
                if ((cnt_inc[CNT_W-1] || (cnt_inc == '0)) && !empty_q) begin
                  state_q <= ST_WAKE;
                end else begin
                  state_q <= ST_DONE;
                end
              end
            end
          end
          ST_SCAN: begin
            if (pool_rsp.done) begin
              if (pool_rsp.found) begin
                count_q       <= dec_q;
                res_blocked_q <= 1'b1;
                tail_q        <= pool_rsp.idx;
                if (empty_q) begin
                  head_q  <= pool_rsp.idx;
                  empty_q <= 1'b0;
                end
              end else begin
                res_pool_full_q <= 1'b1;
              end
              state_q <= ST_DONE;
            end
          end
          ST_WAKE: begin
            res_woken_valid_q <= 1'b1;
            res_woken_proc_q  <= rd_proc_q;
            if (head_q == tail_q) begin
              head_q  <= '0;
              tail_q  <= '0;
              empty_q <= 1'b1;
            end else begin
              head_q <= rd_next_q;
            end
            state_q <= ST_DONE;
          end
          ST_DONE: begin
            if (!out_valid_q || out_ready_i) begin
              out_valid_q   <= 1'b1;
              blocked_q     <= res_blocked_q;
              woken_valid_q <= res_woken_valid_q;
              woken_proc_q  <= res_woken_proc_q;
              pool_full_q   <= res_pool_full_q;
              count_now_q   <= count_q;
              state_q       <= ST_IDLE;
            end
          end
          default: state_q <= ST_IDLE;
        endcase
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign blocked_o     = blocked_q;
  assign woken_valid_o = woken_valid_q;
  assign woken_proc_o  = woken_proc_q;
  assign pool_full_o   = pool_full_q;
  assign count_now_o   = count_now_q;

  a_wake_nonpos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && woken_valid_o) |-> (count_now_o[CNT_W-1] || (count_now_o == '0)))
    else $error("wake reported with positive count");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_q |-> ((head_q == '0) && (tail_q == '0)))
    else $error("empty queue with nonzero pointers");

  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("ready right after input transfer");

  a_scan_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SCAN) && !pool_rsp.done) |=> (state_q == ST_SCAN))
    else $error("left scan before scanner finished");

endmodule

@@ rtl/csq_node_pool.sv @@
// Node pool used marks and the free-node scanner.
// Scans SCAN_W marks per cycle for the lowest unused node; depends on csq_pkg.
module csq_node_pool import csq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pool_req_t req_i,
  output pool_rsp_t rsp_o
);

  logic [POOL_NODES-1:0]         used_q, used_d;
  logic [SCAN_CHUNKS*SCAN_W-1:0] used_pad;
  logic                          scanning_q, scanning_d;
  logic [CHUNK_W-1:0]            chunk_q, chunk_d;
  logic [SCAN_W-1:0]             window;
  logic                          hit;
  logic [SW_W-1:0]               pos;
  logic                          last_chunk;

  always_comb begin
    used_pad = '1;
    used_pad[POOL_NODES-1:0] = used_q;
  end

  assign window     = used_pad[chunk_q*SCAN_W +: SCAN_W];
  assign last_chunk = (chunk_q == CHUNK_W'(SCAN_CHUNKS - 1));

  always_comb begin
    hit = 1'b0;
    pos = '0;
    for (int i = SCAN_W - 1; i >= 0; i--) begin
      if (!window[i]) begin
        hit = 1'b1;
        pos = SW_W'(i);
      end
    end
  end

  assign rsp_o.done  = scanning_q && (hit || last_chunk);
  assign rsp_o.found = scanning_q && hit;
  assign rsp_o.idx   = IDX_W'(chunk_q) * IDX_W'(SCAN_W) + IDX_W'(pos);

  always_comb begin
    scanning_d = scanning_q;
    chunk_d    = chunk_q;
    if (req_i.scan_start) begin
      scanning_d = 1'b1;
      chunk_d    = '0;
    end else if (rsp_o.done) begin
      scanning_d = 1'b0;
    end else if (scanning_q) begin
      chunk_d = chunk_q + CHUNK_W'(1);
    end
  end

  always_comb begin
    used_d = used_q;
    if (req_i.clr_all) begin
      used_d = '0;
    end else begin
      if (req_i.set_en) used_d[req_i.set_idx] = 1'b1;
      if (req_i.clr_en) used_d[req_i.clr_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q     <= '0;
      scanning_q <= 1'b0;
      chunk_q    <= '0;
    end else begin
      used_q     <= used_d;
      scanning_q <= scanning_d;
      chunk_q    <= chunk_d;
    end
  end

  a_found_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.found |-> !used_q[rsp_o.idx])
    else $error("scanner picked a used node");

  a_scan_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.scan_start |=> scanning_q && (chunk_q == '0))
    else $error("scan did not start at first chunk");

endmodule

@@ tb/sv/tb_counting_semaphore_wait_queue.sv @@
// Self-checking testbench for counting_semaphore_wait_queue: directed and random
// acquire/release traffic, APB init_count writes, predicted results in a scoreboard class.
// Depends on csq_pkg and the RTL of the block.
module tb_counting_semaphore_wait_queue;
  import csq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 170;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_AT      = 300;

  typedef struct packed {
    logic                    blocked;
    logic                    woken_valid;
    logic [PROC_W-1:0]       woken_proc;
    logic                    pool_full;
    logic signed [CNT_W-1:0] count_now;
  } sem_result_t;

  class sem_scoreboard;
    int                count;
    bit                used [POOL_NODES];
    logic [PROC_W-1:0] owner [POOL_NODES];
    int                link [POOL_NODES];
    int                head;
    int                tail;
    bit                empty;
    sem_result_t       pending_q[$];
    int                mismatches;
    int                checked;

    function void load(int value);
      count = value;
      foreach (used[i]) used[i] = 1'b0;
      head  = 0;
      tail  = 0;
      empty = 1'b1;
    endfunction

    function void report(string msg);
      $display("error: %s", msg);
      mismatches++;
    endfunction

    function void note(logic op, logic [PROC_W-1:0] pid);
      sem_result_t r;
      int          nxt;
      int          slot;
      r = '0;
      if (op == CMD_ACQUIRE) begin
        nxt = (count > int'(CNT_MIN)) ? count - 1 : int'(CNT_MIN);
        if (nxt < 0) begin
          slot = -1;
          for (int i = 0; i < POOL_NODES; i++) if (!used[i] && slot < 0) slot = i;
          if (slot < 0) begin
            r.pool_full = 1'b1;
          end else begin
            used[slot]  = 1'b1;
            owner[slot] = pid;
            if (empty) begin
              head  = slot;
              empty = 1'b0;
            end else begin
              link[tail] = slot;
            end
            tail      = slot;
            count     = nxt;
            r.blocked = 1'b1;
          end
        end else begin
          count = nxt;
        end
      end else begin
        count = (count < int'(CNT_MAX)) ? count + 1 : int'(CNT_MAX);
        if (count <= 0 && !empty) begin
          r.woken_valid = 1'b1;
          r.woken_proc  = owner[head];
          used[head]    = 1'b0;
          if (head == tail) begin
            head  = 0;
            tail  = 0;
            empty = 1'b1;
          end else begin
            head = link[head];
          end
        end
      end
      r.count_now = count[CNT_W-1:0];
      pending_q.push_back(r);
    endfunction

    function void check(sem_result_t got);
      sem_result_t want;
      checked++;
      if (pending_q.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", checked));
        return;
      end
      want = pending_q.pop_front();
      if (got.blocked !== want.blocked)
        report($sformatf("result %0d blocked %b, want %b", checked, got.blocked, want.blocked));
      if (got.woken_valid !== want.woken_valid)
        report($sformatf("result %0d woken_valid %b, want %b", checked,
                         got.woken_valid, want.woken_valid));
      if (got.woken_proc !== want.woken_proc)
        report($sformatf("result %0d woken_proc %0d, want %0d", checked,
                         got.woken_proc, want.woken_proc));
      if (got.pool_full !== want.pool_full)
        report($sformatf("result %0d pool_full %b, want %b", checked,
                         got.pool_full, want.pool_full));
      if (got.count_now !== want.count_now)
        report($sformatf("result %0d count_now %0d, want %0d", checked,
                         got.count_now, want.count_now));
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [APB_AW-1:0]       paddr;
  logic [APB_DW-1:0]       pwdata;
  logic [APB_DW-1:0]       prdata;
  logic                    pready;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic                    cmd_i;
  logic [PROC_W-1:0]       proc_id_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic                    blocked_o;
  logic                    woken_valid_o;
  logic [PROC_W-1:0]       woken_proc_o;
  logic                    pool_full_o;
  logic signed [CNT_W-1:0] count_now_o;

  sem_scoreboard sb = new();
  bit            calm;
  int            quiet;

  counting_semaphore_wait_queue DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .proc_id_i     (proc_id_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .blocked_o     (blocked_o),
    .woken_valid_o (woken_valid_o),
    .woken_proc_o  (woken_proc_o),
    .pool_full_o   (pool_full_o),
    .count_now_o   (count_now_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check({blocked_o, woken_valid_o, woken_proc_o, pool_full_o, count_now_o});
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable && pready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet == STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int  stall_left;
    bit  held;
    stall_left = 0;
    held       = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && sb.checked >= HOLD_AT) begin
        held       = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 8) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_item(logic op, logic [PROC_W-1:0] pid);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= op;
    proc_id_i  <= pid;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note(op, pid);
  endtask

  task automatic drain_queue();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_init_count(int value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_INIT_COUNT, 2'b00};
    pwdata  <= APB_DW'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.load(value);
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[INIT_W-1:0] !== INIT_W'(value))
      sb.report($sformatf("init_count reads %0d, want %0d", prdata[INIT_W-1:0], value));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic random_traffic(int quota);
    int n;
    int len;
    int kind;
    n = 0;
    while (n < quota) begin
      kind = (n == 0) ? 0 : $urandom_range(0, 9);
      len  = (n == 0) ? $urandom_range(60, 80) : $urandom_range(1, 80);
      if (len > quota - n) len = quota - n;
      for (int k = 0; k < len; k++) begin
        if (kind < 5)
          send_item(CMD_ACQUIRE, PROC_W'($urandom));
        else if (kind < 9)
          send_item(CMD_RELEASE, PROC_W'($urandom));
        else
          send_item(1'($urandom_range(0, 1)), PROC_W'($urandom));
      end
      n += len;
    end
  endtask

  initial begin
    int init_val;
    calm        = 1'b0;
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    cmd_i       = CMD_ACQUIRE;
    proc_id_i   = '0;
    sb.load(0);
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_item(CMD_ACQUIRE, PROC_W'(0));
    send_item(CMD_ACQUIRE, PROC_W'(63));
    send_item(CMD_RELEASE, PROC_W'(0));
    send_item(CMD_ACQUIRE, PROC_W'(21));
    send_item(CMD_RELEASE, PROC_W'(63));
    send_item(CMD_RELEASE, PROC_W'(0));
    send_item(CMD_RELEASE, PROC_W'(0));
    send_item(CMD_ACQUIRE, PROC_W'(63));
    drain_queue();

    write_init_count(int'(CNT_MAX));
    send_item(CMD_RELEASE, PROC_W'(63));
    send_item(CMD_ACQUIRE, PROC_W'(0));
    send_item(CMD_RELEASE, PROC_W'(0));
    send_item(CMD_RELEASE, PROC_W'(42));
    drain_queue();

    write_init_count(1);
    send_item(CMD_ACQUIRE, PROC_W'(0));
    send_item(CMD_ACQUIRE, PROC_W'(63));
    send_item(CMD_RELEASE, PROC_W'(63));
    drain_queue();

    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0, 9:    init_val = 0;
        1:       init_val = 1;
        2:       init_val = int'(CNT_MAX);
        3:       init_val = 5;
        4:       init_val = $urandom_range(0, 80);
        5:       init_val = 63;
        6:       init_val = 64;
        7:       init_val = $urandom_range(0, int'(CNT_MAX));
        default: init_val = 2;
      endcase
      calm = (phase == 9);
      write_init_count(init_val);
      random_traffic(PHASE_ITEMS);
      drain_queue();
    end

    if (sb.pending_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending_q.size()));
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/csq_pkg.sv
rtl/csq_node_pool.sv
rtl/counting_semaphore_wait_queue.sv
tb/sv/tb_counting_semaphore_wait_queue.sv
